// File: hw/rtl/integer_stack_machine_top_macros.svh
// Assertion shorthands for the stack machine checker.
// Both expect signals named clk and rst_n in the scope where they are used.
`ifndef INTEGER_STACK_MACHINE_TOP_MACROS_SVH
`define INTEGER_STACK_MACHINE_TOP_MACROS_SVH

// Same-cycle implication, off during reset
`define ISM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stack machine check failed");

// Next-cycle implication, off during reset
`define ISM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stack machine check failed");

`endif

// File: hw/rtl/ism_pkg.sv
`default_nettype none

package ism_pkg;

  localparam int DataW = 64;

  // Instruction codes
  localparam logic [3:0] KIND_CONST = 4'd0;
  localparam logic [3:0] KIND_ADD   = 4'd1;
  localparam logic [3:0] KIND_SUB   = 4'd2;
  localparam logic [3:0] KIND_MUL   = 4'd3;
  localparam logic [3:0] KIND_DIV   = 4'd4;
  localparam logic [3:0] KIND_MAX   = 4'd5;
  localparam logic [3:0] KIND_MIN   = 4'd6;
  localparam logic [3:0] KIND_NEG   = 4'd7;
  localparam logic [3:0] KIND_DUP   = 4'd8;
  localparam logic [3:0] KIND_SWAP  = 4'd9;
  localparam logic [3:0] KIND_END   = 4'd10;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic mul_load;
    logic div_start;
    logic swap_wr;
    logic finish;
  } ism_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [3:0] kind;
    logic [1:0] err;
    logic       out_busy;
    logic       div_busy;
  } ism_stat_t;

  // Unused codes behave as END
  function automatic logic is_end(input logic [3:0] k);
    return k >= KIND_END;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ism_div.sv
`default_nettype none

module ism_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ism_pkg::DataW-1:0]   num,
  input  wire logic [ism_pkg::DataW-1:0]   den,
  output logic                             busy,
  output logic [ism_pkg::DataW-1:0]        quot
);
  import ism_pkg::*;

  localparam int CntW = $clog2(DataW);

  logic              busy_r;
  logic [CntW-1:0]   cnt_r;
  logic [DataW-1:0]  rem_r;
  logic [DataW-1:0]  quo_r;
  logic [DataW-1:0]  dmag_r;
  logic              neg_r;

  logic [DataW:0]    rem_sh;
  logic [DataW:0]    diff;
  logic [DataW-1:0]  nmag;
  logic [DataW-1:0]  dmag;

  // Magnitudes of the signed operands
  assign nmag = num[DataW-1] ? (DataW'(0) - num) : num;
  assign dmag = den[DataW-1] ? (DataW'(0) - den) : den;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign rem_sh = {rem_r, quo_r[DataW-1]};
  assign diff   = rem_sh - {1'b0, dmag_r};

  // Control: run one step per cycle, DataW steps in all
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + CntW'(1);
      if (cnt_r == CntW'(DataW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= nmag;
      dmag_r <= dmag;
      neg_r  <= num[DataW-1] ^ den[DataW-1];
    end else if (busy_r) begin
      if (!diff[DataW]) begin
        rem_r <= diff[DataW-1:0];
        quo_r <= {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[DataW-1:0];
        quo_r <= {quo_r[DataW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quot = neg_r ? (DataW'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

// File: hw/rtl/ism_dpath.sv
`default_nettype none

module ism_dpath #(
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire ism_pkg::ism_cmd_t                cmd,
  output ism_pkg::ism_stat_t                    stat,
  input  wire logic [3:0]                       in_kind,
  input  wire logic signed [ism_pkg::DataW-1:0] in_operand,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_status,
  output logic                                  out_finished,
  output logic signed [ism_pkg::DataW-1:0]      out_result
);
  import ism_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  // Stack memory, two registered read ports, one write port
  logic [DataW-1:0] mem [STACK_DEPTH];

  logic [DW-1:0]    depth_r;
  logic [DW-1:0]    depth_nxt;
  logic [3:0]       kind_r;
  logic [DataW-1:0] operand_r;
  logic [DataW-1:0] a_r;
  logic [DataW-1:0] b_r;

  logic [DataW-1:0] p_ll_r;
  logic [31:0]      p_lh_r;
  logic [31:0]      p_hl_r;
  logic [DataW-1:0] p_ll_nxt;
  logic [31:0]      p_lh_nxt;
  logic [31:0]      p_hl_nxt;
  logic [DataW-1:0] prod;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic             out_finished_r;
  logic [DataW-1:0] out_result_r;

  logic [DW-1:0]    top_ext;
  logic [DW-1:0]    nxt_ext;
  logic [AW-1:0]    top_idx;
  logic [AW-1:0]    nxt_idx;
  logic [AW-1:0]    push_idx;
  logic             full;
  logic             empty;
  logic             lt2;
  logic [1:0]       err;
  logic [DataW-1:0] bin_res;
  logic [DataW-1:0] quot;
  logic             div_busy;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DataW-1:0] wr_data;
  logic             ok_end;

  // Stack pointers derived from the depth
  assign top_ext  = depth_r - DW'(1);
  assign nxt_ext  = depth_r - DW'(2);
  assign top_idx  = top_ext[AW-1:0];
  assign nxt_idx  = nxt_ext[AW-1:0];
  assign push_idx = depth_r[AW-1:0];
  assign full     = (depth_r == DW'(STACK_DEPTH));
  assign empty    = (depth_r == '0);
  assign lt2      = (depth_r < DW'(2));

  // Capture the instruction on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r    <= in_kind;
      operand_r <= in_operand;
    end
  end

  // Read top and next entries on accept
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a_r <= mem[top_idx];
      b_r <= mem[nxt_idx];
    end
  end

  // Error check on the captured instruction
  always_comb begin
    err = ST_OK;
    case (kind_r) inside
      KIND_CONST: begin
        if (full) err = ST_OVER;
      end
      [KIND_ADD:KIND_MIN]: begin
        if (lt2) err = ST_UNDER;
        else if (kind_r == KIND_DIV && b_r == '0) err = ST_DIVZ;
      end
      KIND_NEG: begin
        if (empty) err = ST_UNDER;
      end
      KIND_DUP: begin
        if (empty) err = ST_UNDER;
        else if (full) err = ST_OVER;
      end
      KIND_SWAP: begin
        if (lt2) err = ST_UNDER;
      end
      default: begin
        if (empty) err = ST_UNDER;
      end
    endcase
  end

  // Split 64-bit multiply: three 32x32 partial products, registered
  assign p_ll_nxt = DataW'(a_r[31:0]) * DataW'(b_r[31:0]);
  assign p_lh_nxt = a_r[31:0] * b_r[63:32];
  assign p_hl_nxt = a_r[63:32] * b_r[31:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      p_ll_r <= p_ll_nxt;
      p_lh_r <= p_lh_nxt;
      p_hl_r <= p_hl_nxt;
    end
  end

  assign prod = p_ll_r + {p_lh_r + p_hl_r, 32'b0};

  ism_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (a_r),
    .den   (b_r),
    .busy  (div_busy),
    .quot  (quot)
  );

  // Binary operation result
  always_comb begin
    case (kind_r)
      KIND_ADD: bin_res = a_r + b_r;
      KIND_SUB: bin_res = a_r - b_r;
      KIND_MUL: bin_res = prod;
      KIND_DIV: bin_res = quot;
      KIND_MAX: bin_res = ($signed(a_r) > $signed(b_r)) ? a_r : b_r;
      default:  bin_res = ($signed(b_r) > $signed(a_r)) ? a_r : b_r;
    endcase
  end

  // Write-back and depth update
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = push_idx;
    wr_data   = operand_r;
    depth_nxt = depth_r;
    if (cmd.swap_wr) begin
      wr_en   = 1'b1;
      wr_addr = top_idx;
      wr_data = b_r;
    end else if (cmd.finish && err == ST_OK) begin
      case (kind_r) inside
        KIND_CONST: begin
          wr_en     = 1'b1;
          depth_nxt = depth_r + DW'(1);
        end
        [KIND_ADD:KIND_MIN]: begin
          wr_en     = 1'b1;
          wr_addr   = nxt_idx;
          wr_data   = bin_res;
          depth_nxt = top_ext;
        end
        KIND_NEG: begin
          wr_en   = 1'b1;
          wr_addr = top_idx;
          wr_data = DataW'(0) - a_r;
        end
        KIND_DUP: begin
          wr_en     = 1'b1;
          wr_data   = a_r;
          depth_nxt = depth_r + DW'(1);
        end
        KIND_SWAP: begin
          wr_en   = 1'b1;
          wr_addr = nxt_idx;
          wr_data = a_r;
        end
        default: begin
          depth_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Result register: load on finish, drop when the beat is taken
  assign ok_end = (err == ST_OK) && is_end(kind_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r   <= err;
      out_finished_r <= ok_end;
      out_result_r   <= ok_end ? a_r : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_finished = out_finished_r;
  assign out_result   = out_result_r;

  assign stat.kind     = kind_r;
  assign stat.err      = err;
  assign stat.out_busy = out_valid_r & ~out_ready;
  assign stat.div_busy = div_busy;

endmodule

`default_nettype wire

// File: hw/rtl/ism_ctrl.sv
`default_nettype none

module ism_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ism_pkg::ism_stat_t   stat,
  output ism_pkg::ism_cmd_t         cmd
);
  import ism_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MULW,
    S_DIVW,
    S_SWAPW
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   go;

  // Finish only when the result register is free or being emptied
  assign go       = ~stat.out_busy;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.accept    = in_valid & in_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.err != ST_OK) begin
          if (go) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          case (stat.kind)
            KIND_MUL: begin
              cmd.mul_load = 1'b1;
              state_nxt    = S_MULW;
            end
            KIND_DIV: begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIVW;
            end
            KIND_SWAP: begin
              cmd.swap_wr = 1'b1;
              state_nxt   = S_SWAPW;
            end
            default: begin
              if (go) begin
                cmd.finish = 1'b1;
                state_nxt  = S_IDLE;
              end
            end
          endcase
        end
      end
      S_MULW, S_SWAPW: begin
        if (go) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DIVW: begin
        if (!stat.div_busy && go) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/integer_stack_machine_top.sv
`default_nettype none

// Stack machine calculator on a signed 64-bit operand stack of STACK_DEPTH
// entries; every instruction beat yields exactly one result beat carrying a
// status, a finished flag and the value popped by END. The stack lives in a
// dual-read single-write memory, so an instruction is read on accept and
// executed from the registered entries in the EXEC state: CONST, ADD, SUB,
// MAX, MIN, NEG, DUP, END and any error finish there, MUL and SWAP pass a
// wait state (split multiply register, second memory write), and DIV waits
// for its bit-serial divider, which retires one quotient bit per cycle. One
// instruction is in flight at a time; a new one is taken while the previous
// result waits at the output, and a result held there stalls the finish of
// the next. The stack needs no initialization after reset.
module integer_stack_machine_top #(
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [3:0]                       in_kind,
  input  wire logic signed [ism_pkg::DataW-1:0] in_operand,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_status,
  output logic                                  out_finished,
  output logic signed [ism_pkg::DataW-1:0]      out_result
);
  import ism_pkg::*;

  ism_cmd_t  cmd;
  ism_stat_t stat;

  ism_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ism_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .in_kind      (in_kind),
    .in_operand   (in_operand),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_finished (out_finished),
    .out_result   (out_result)
  );

endmodule

`default_nettype wire

// File: hw/rtl/ism_checker.sv
`default_nettype none

`include "integer_stack_machine_top_macros.svh"

module ism_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [1:0]                       out_status,
  input wire logic                             out_finished,
  input wire logic signed [ism_pkg::DataW-1:0] out_result
);
  import ism_pkg::*;

  // Hold a stalled result beat
  `ISM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result))

  // A finished beat always reports success
  `ISM_ASSERT_NOW(a_fin_ok, out_valid && out_finished, out_status == ST_OK)

  // Only a finished beat carries a value
  `ISM_ASSERT_NOW(a_res_zero, out_valid && !out_finished, out_result == '0)

  // Errors never mark the program finished
  `ISM_ASSERT_NOW(a_err_nofin, out_valid && out_status != ST_OK, !out_finished)

endmodule

bind integer_stack_machine_top ism_checker u_ism_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_finished (out_finished),
  .out_result   (out_result)
);

`default_nettype wire

// File: sim/integer_stack_machine_top_tb.sv
`timescale 1ns / 1ps

module integer_stack_machine_top_tb;
  import ism_pkg::*;

  localparam int          StackDepth = 1024;
  localparam int          TotalItems = 1550;
  localparam int          QuietLimit = 4000;
  localparam int          LongHold   = 400;
  localparam logic [63:0] MinVal     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxVal     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NegOne     = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  status;
    logic        finished;
    logic [63:0] result;
  } sm_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic [3:0]               in_kind;
  logic signed [DataW-1:0]  in_operand;
  logic                     out_valid;
  logic                     out_ready;
  logic [1:0]               out_status;
  logic                     out_finished;
  logic signed [DataW-1:0]  out_result;

  // Shadow copy of the operand stack
  logic [63:0]  stk_mem [StackDepth];
  int           stk_depth;
  sm_result_t   expected_results [$];

  int  items_sent;
  int  err_cnt;
  int  quiet_cycles;
  bit  tx_idle_en;
  bit  rx_idle_en;
  bit  hold_long;

  integer_stack_machine_top #(
    .STACK_DEPTH(StackDepth)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_operand   (in_operand),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_finished (out_finished),
    .out_result   (out_result)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Execute one instruction on the shadow stack and return its result beat
  function automatic sm_result_t stack_exec(input logic [3:0] kind, input logic [63:0] operand);
    sm_result_t  r;
    logic [63:0] a, b, v, nmag, dmag, q;
    r.status   = ST_OK;
    r.finished = 1'b0;
    r.result   = '0;
    a = '0;
    b = '0;
    v = '0;
    if (stk_depth >= 1) a = stk_mem[stk_depth-1];
    if (stk_depth >= 2) b = stk_mem[stk_depth-2];
    case (kind)
      KIND_CONST: begin
        if (stk_depth >= StackDepth) begin
          r.status = ST_OVER;
        end else begin
          stk_mem[stk_depth] = operand;
          stk_depth++;
        end
      end
      KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_MAX, KIND_MIN: begin
        if (stk_depth < 2) begin
          r.status = ST_UNDER;
        end else begin
          case (kind)
            KIND_ADD: v = a + b;
            KIND_SUB: v = a - b;
            KIND_MUL: v = a * b;
            KIND_DIV: begin
              // Divide magnitudes, then fix the sign: truncates toward zero
              if (b == '0) begin
                r.status = ST_DIVZ;
              end else begin
                nmag = a[63] ? -a : a;
                dmag = b[63] ? -b : b;
                q    = nmag / dmag;
                v    = (a[63] ^ b[63]) ? -q : q;
              end
            end
            KIND_MAX: v = ($signed(a) > $signed(b)) ? a : b;
            default:  v = ($signed(b) > $signed(a)) ? a : b;
          endcase
          if (r.status == ST_OK) begin
            stk_mem[stk_depth-2] = v;
            stk_depth--;
          end
        end
      end
      KIND_NEG: begin
        if (stk_depth < 1) r.status = ST_UNDER;
        else stk_mem[stk_depth-1] = -a;
      end
      KIND_DUP: begin
        if (stk_depth < 1) begin
          r.status = ST_UNDER;
        end else if (stk_depth >= StackDepth) begin
          r.status = ST_OVER;
        end else begin
          stk_mem[stk_depth] = a;
          stk_depth++;
        end
      end
      KIND_SWAP: begin
        if (stk_depth < 2) begin
          r.status = ST_UNDER;
        end else begin
          stk_mem[stk_depth-1] = b;
          stk_mem[stk_depth-2] = a;
        end
      end
      default: begin
        // END and every unused code
        if (stk_depth < 1) begin
          r.status = ST_UNDER;
        end else begin
          r.result   = a;
          r.finished = 1'b1;
          stk_depth  = 0;
        end
      end
    endcase
    return r;
  endfunction

  // Mix of full-width, small, extreme and mid-size operands
  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      3: begin
        v = 64'($urandom_range(0, 12));
        v = v - 64'd6;
      end
      4: begin
        case ($urandom_range(0, 4))
          0: v = MinVal;
          1: v = MaxVal;
          2: v = NegOne;
          3: v = 64'd1;
          default: v = '0;
        endcase
      end
      5: begin
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1) == 0) v = -v;
      end
      default: ;
    endcase
    return v;
  endfunction

  // Offer one instruction beat and hold it until accepted
  task automatic send_instr(input logic [3:0] kind, input logic [63:0] operand);
    int gap;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_operand <= operand;
    expected_results.push_back(stack_exec(kind, operand));
    items_sent++;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Stop offering and wait for every pending result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_underflow();
    send_instr(KIND_DIV, rand_operand());
    send_instr(KIND_NEG, rand_operand());
    send_instr(KIND_DUP, rand_operand());
    send_instr(KIND_END, rand_operand());
    send_instr(KIND_CONST, 64'd5);
    send_instr(KIND_SWAP, rand_operand());
    send_instr(KIND_END + 4'd1, rand_operand());
    wait_results_drained();
  endtask

  task automatic test_arith_corners();
    // divide by zero, then the same operands swapped
    send_instr(KIND_CONST, '0);
    send_instr(KIND_CONST, 64'd7);
    send_instr(KIND_DIV, '0);
    send_instr(KIND_SWAP, '0);
    send_instr(KIND_DIV, '0);
    // most negative over minus one wraps; its negation too
    send_instr(KIND_CONST, NegOne);
    send_instr(KIND_CONST, MinVal);
    send_instr(KIND_DIV, '0);
    send_instr(KIND_NEG, '0);
    send_instr(KIND_CONST, MaxVal);
    send_instr(KIND_ADD, '0);
    send_instr(KIND_CONST, MaxVal);
    send_instr(KIND_MUL, '0);
    send_instr(KIND_DUP, '0);
    send_instr(KIND_SUB, '0);
    // truncation toward zero: -7 / 2
    send_instr(KIND_CONST, 64'd2);
    send_instr(KIND_CONST, -64'd7);
    send_instr(KIND_DIV, '0);
    send_instr(KIND_MAX, '0);
    send_instr(KIND_CONST, 64'd3);
    send_instr(KIND_MIN, '0);
    send_instr(4'hF, MaxVal);
    wait_results_drained();
  endtask

  // Fill the stack to the top while the receiver first holds off
  task automatic test_stack_full();
    int pick;
    rx_idle_en = 1'b1;
    hold_long  = 1'b1;
    while (stk_depth < StackDepth) begin
      pick = $urandom_range(0, 19);
      if (pick < 16)       send_instr(KIND_CONST, rand_operand());
      else if (pick < 18)  send_instr(KIND_DUP, rand_operand());
      else if (pick == 18) send_instr(KIND_SWAP, rand_operand());
      else                 send_instr(4'($urandom_range(KIND_ADD, KIND_NEG)), rand_operand());
    end
    send_instr(KIND_CONST, rand_operand());
    send_instr(KIND_DUP, rand_operand());
    send_instr(KIND_MUL, rand_operand());
    send_instr(KIND_CONST, rand_operand());
    send_instr(KIND_DUP, rand_operand());
    send_instr(KIND_END, rand_operand());
    wait_results_drained();
  endtask

  // Short programs, most ending in END or an unused code, with some noise beats
  task automatic test_random_programs();
    int         n_push;
    int         n_ops;
    logic [3:0] kind;
    while (items_sent < TotalItems) begin
      if (items_sent >= TotalItems - 150) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) send_instr(4'($urandom), rand_operand());
      end else begin
        n_push = $urandom_range(1, 6);
        n_ops  = $urandom_range(1, 8);
        repeat (n_push) send_instr(KIND_CONST, rand_operand());
        repeat (n_ops) begin
          if ($urandom_range(0, 3) == 0) kind = KIND_CONST;
          else kind = 4'($urandom_range(KIND_ADD, KIND_SWAP));
          send_instr(kind, rand_operand());
        end
        if ($urandom_range(0, 4) != 0) begin
          if ($urandom_range(0, 7) == 0) kind = 4'($urandom_range(int'(KIND_END) + 1, 15));
          else kind = KIND_END;
          send_instr(kind, rand_operand());
        end
      end
    end
    wait_results_drained();
  endtask

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    sm_result_t exp_r;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with none expected, status %0d result %0h",
                 $time, out_status, out_result);
        err_cnt++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          err_cnt++;
        end
        if (out_finished !== exp_r.finished) begin
          $display("%0t: finished expected %0d actual %0d",
                   $time, exp_r.finished, out_finished);
          err_cnt++;
        end
        if (out_result !== exp_r.result) begin
          $display("%0t: result expected %0h actual %0h", $time, exp_r.result, out_result);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
        $display("integer_stack_machine_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_CONST;
    in_operand = '0;
    stk_depth  = 0;
    items_sent = 0;
    err_cnt    = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    hold_long  = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_underflow();
    test_arith_corners();
    test_stack_full();
    test_random_programs();

    repeat (20) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("integer_stack_machine_top verification clean");
    end else begin
      $display("integer_stack_machine_top verification failed");
    end
    $finish;
  end

endmodule
